>>> sv/crc32_frame_fcs_engine_defines.svh
// assertion macros for the crc32 frame fcs engine, used by crcfcs_out
// expects clk and rst_n in scope where used
`ifndef CRC32_FRAME_FCS_ENGINE_DEFINES_SVH
`define CRC32_FRAME_FCS_ENGINE_DEFINES_SVH

// checked outside reset
`define CRCFCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked across reset as well
`define CRCFCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/crcfcs_pkg.sv
// types, codes and crc byte update for the crc32 frame fcs engine
// no dependencies
`timescale 1ns / 1ps

package crcfcs_pkg;

  localparam logic [31:0] NORMAL_POLY   = 32'h04C1_1DB7;
  localparam logic [31:0] REFLECT_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] REFLECT_RESID = 32'hDEBB_20E3;
  localparam logic [31:0] NORMAL_RESID  = 32'h0000_0000;
  localparam logic [31:0] SEED_RESET    = 32'hFFFF_FFFF;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PHASE_DATA = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_FCS0 = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_FCS1 = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_FCS2 = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_FCS3 = 3'd4;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_TASK = 2'd1,
    REG_SEED = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    TASK_PLAIN  = 2'd0,
    TASK_APPEND = 2'd1,
    TASK_CHECK  = 2'd2
  } frame_task_t;

  typedef struct packed {
    logic        reflected;
    logic [1:0]  frame_task;
    logic [31:0] seed;
    logic        seed_load;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] crc;
    logic [31:0] fcs_word;
    logic        ok;
    logic        append;
  } item_t;

  function automatic logic [31:0] crc_byte_update(input logic [31:0] crc_in,
                                                  input logic [7:0]  data,
                                                  input logic        refl);
    logic [31:0] r;
    r = crc_in;
    if (refl) begin
      r = r ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ REFLECT_POLY) : (r >> 1);
      end
    end else begin
      r = r ^ {data, 24'd0};
      for (int k = 0; k < 8; k++) begin
        r = r[31] ? ((r << 1) ^ NORMAL_POLY) : (r << 1);
      end
    end
    return r;
  endfunction

endpackage

>>> sv/crcfcs_regs.sv
// configuration registers behind the apb-style port
// depends on crcfcs_pkg
`timescale 1ns / 1ps

module crcfcs_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [crcfcs_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output crcfcs_pkg::cfg_t            cfg
);
  import crcfcs_pkg::*;

  logic        mode_r, mode_nxt;
  logic [1:0]  task_r, task_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic        wr_en;
  logic        seed_load;
  logic [1:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_comb begin
    mode_nxt  = mode_r;
    task_nxt  = task_r;
    seed_nxt  = seed_r;
    seed_load = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODE: mode_nxt = cfg_pwdata[0];
        REG_TASK: task_nxt = cfg_pwdata[1:0];
        REG_SEED: begin
          seed_nxt  = cfg_pwdata;
          seed_load = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE: cfg_prdata = {31'd0, mode_r};
      REG_TASK: cfg_prdata = {30'd0, task_r};
      REG_SEED: cfg_prdata = seed_r;
      default:  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      task_r <= TASK_PLAIN;
      seed_r <= SEED_RESET;
    end else begin
      mode_r <= mode_nxt;
      task_r <= task_nxt;
      seed_r <= seed_nxt;
    end
  end

  assign cfg.reflected  = mode_r;
  assign cfg.frame_task = task_r;
  assign cfg.seed       = seed_nxt;
  assign cfg.seed_load  = seed_load;

endmodule

>>> sv/crcfcs_core.sv
// running crc register, byte update, fcs word and residue check
// depends on crcfcs_pkg
`timescale 1ns / 1ps

module crcfcs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  crcfcs_pkg::cfg_t  cfg,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output crcfcs_pkg::item_t item
);
  import crcfcs_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_upd;
  logic [31:0] crc_inv;
  logic [31:0] resid;

  assign crc_upd = crc_byte_update(crc_r, data_byte, cfg.reflected);
  assign crc_inv = ~crc_upd;
  assign resid   = cfg.reflected ? REFLECT_RESID : NORMAL_RESID;

  always_comb begin
    crc_nxt = crc_r;
    if (cfg.seed_load) begin
      crc_nxt = cfg.seed;
    end else if (accept) begin
      crc_nxt = last_byte ? cfg.seed : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= SEED_RESET;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  // fcs word holds the bytes in send order, first byte at the top
  assign item.data_byte = data_byte;
  assign item.crc       = crc_upd;
  assign item.fcs_word  = cfg.reflected ?
                          {crc_inv[7:0], crc_inv[15:8], crc_inv[23:16], crc_inv[31:24]} :
                          crc_upd;
  assign item.ok        = last_byte && (cfg.frame_task == TASK_CHECK) && (crc_upd == resid);
  assign item.append    = last_byte && (cfg.frame_task == TASK_APPEND);

endmodule

>>> sv/crcfcs_out.sv
// two-entry result stage: output register plus skid slot, fcs byte sequencing
// depends on crcfcs_pkg and crc32_frame_fcs_engine_defines.svh
`timescale 1ns / 1ps
`include "crc32_frame_fcs_engine_defines.svh"

module crcfcs_out (
  input  logic              clk,
  input  logic              rst_n,
  input  crcfcs_pkg::item_t item,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // out_byte[7:0], crc_value[39:8]
  output logic [1:0]        out_tuser,  // is_fcs[0], crc_ok[1]
  output logic              out_tlast,  // end_of_run
  output logic              accept
);
  import crcfcs_pkg::*;

  item_t                out_item_r, out_item_nxt;
  item_t                skid_item_r, skid_item_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic                 xfer;
  logic                 done;
  logic                 out_free;
  logic [7:0]           res_byte;
  logic                 res_fcs;
  logic                 res_ok;
  logic                 res_last;

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign xfer      = out_valid_r && out_tready;
  assign done      = xfer && res_last;
  assign out_free  = !out_valid_r || done;

  always_comb begin
    res_byte = out_item_r.data_byte;
    res_fcs  = 1'b1;
    res_ok   = 1'b0;
    res_last = 1'b0;
    case (phase_r)
      PHASE_DATA: begin
        res_fcs  = 1'b0;
        res_ok   = out_item_r.ok;
        res_last = !out_item_r.append;
      end
      PHASE_FCS0: res_byte = out_item_r.fcs_word[31:24];
      PHASE_FCS1: res_byte = out_item_r.fcs_word[23:16];
      PHASE_FCS2: res_byte = out_item_r.fcs_word[15:8];
      PHASE_FCS3: begin
        res_byte = out_item_r.fcs_word[7:0];
        res_last = 1'b1;
      end
      default: res_last = 1'b1;
    endcase
  end

  always_comb begin
    out_item_nxt   = out_item_r;
    skid_item_nxt  = skid_item_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    phase_nxt      = phase_r;
    if (out_free) begin
      phase_nxt = PHASE_DATA;
      if (skid_valid_r) begin
        out_item_nxt   = skid_item_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_item_nxt  = item;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else begin
      if (accept) begin
        skid_item_nxt  = item;
        skid_valid_nxt = 1'b1;
      end
      if (xfer) begin
        phase_nxt = phase_r + PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      phase_r      <= PHASE_DATA;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      phase_r      <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_item_r.crc, res_byte};
  assign out_tuser  = {res_ok, res_fcs};
  assign out_tlast  = res_last;

  `CRCFCS_ASSERT(a_skid_behind_out, skid_valid_r |-> out_valid_r, "skid slot full with output empty")
  `CRCFCS_ASSERT(a_phase_range, out_valid_r |-> (phase_r <= PHASE_FCS3), "fcs phase out of range")
  `CRCFCS_ASSERT(a_fcs_only_append, (out_valid_r && (phase_r != PHASE_DATA)) |-> out_item_r.append, "fcs byte without append")
  `CRCFCS_ASSERT(a_skid_drains, (done && skid_valid_r) |=> (out_valid_r && !skid_valid_r && (phase_r == PHASE_DATA)), "skid item not moved up")
  `CRCFCS_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_valid_r && !skid_valid_r), "result stage not empty after reset")

endmodule

>>> sv/crc32_frame_fcs_engine.sv
// Byte-serial CRC-32 engine: one data byte per input transfer, one result per byte, and in
// the append task four more results carrying the FCS after a frame's last byte. A byte is
// taken every clock cycle while the skid slot is empty; the CRC update of one byte is done
// between the input and the result register, and the result goes to the skid slot instead
// while the output register waits, so one more byte is taken while a result waits; after an
// appended frame the input pauses for the four FCS transfers once the skid slot is full.
// Configuration: reflected_mode at 0x0, frame_task at 0x4, crc_seed at 0x8; a seed write
// also reloads the running CRC. Write configuration only while no results are pending.
// Depends on crcfcs_pkg, crcfcs_regs, crcfcs_core and crcfcs_out.
`timescale 1ns / 1ps

module crc32_frame_fcs_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // data_byte[7:0]
  input  logic                          in_tlast,   // last_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // out_byte[7:0], crc_value[39:8]
  output logic [1:0]                    out_tuser,  // is_fcs[0], crc_ok[1]
  output logic                          out_tlast,  // end_of_run
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [crcfcs_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import crcfcs_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  accept;

  crcfcs_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  crcfcs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .item      (item)
  );

  crcfcs_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .accept     (accept)
  );

endmodule
